>>> rtl/core/lph_pkg.sv
// shared constants, codes and control types of the linear probing hash table
`timescale 1ns / 1ps
`default_nettype none

package lph_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int ADDR_W    = $clog2(MAX_SLOTS);
    localparam int NUM_W     = ADDR_W + 1;

    localparam int SIZE_W = 11;
    localparam int KEY_W  = 31;
    localparam int SLOT_W = 10;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int CNT_W  = $clog2(KEY_W);
    localparam int RAM_W  = KEY_W + 2;

    localparam int IN_TDATA_W  = ((KEY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SLOT_W + KEY_W + 7) / 8) * 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] RES_OK        = 2'd0;
    localparam logic [STAT_W-1:0] RES_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] RES_FULL      = 2'd2;

    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_USED    = 2'd1;
    localparam logic [1:0] SLOT_DELETED = 2'd2;

    typedef struct packed {
        logic load;
        logic div_step;
        logic rd;
        logic advance;
        logic wr_used;
        logic wr_deleted;
        logic clear_step;
        logic emit_hit;
        logic emit_miss;
        logic emit_full;
    } lph_cmd_t;

    typedef struct packed {
        logic            clear_last;
        logic            div_last;
        logic [OP_W-1:0] op;
        logic            slot_free;
        logic            slot_empty;
        logic            key_match;
        logic            probe_last;
        logic            out_free;
    } lph_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/lph_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lph_ctrl.sv
// controller state machine of the linear probing hash table
`timescale 1ns / 1ps
`default_nettype none

module lph_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lph_pkg::lph_stat_t stat,
    output lph_pkg::lph_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_CHECK,
        ST_REJECT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    assign in_ready = in_ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    if (stat.op inside {lph_pkg::OP_INSERT, lph_pkg::OP_FIND,
                                        lph_pkg::OP_REMOVE})
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_REJECT;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.op == lph_pkg::OP_INSERT)
                begin
                    if (stat.slot_free)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.wr_used  = 1'b1;
                            cmd.emit_hit = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    else if (stat.probe_last)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit_full = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_READ;
                    end
                end
                else if (stat.key_match)
                begin
                    if (stat.out_free)
                    begin
                        cmd.wr_deleted = (stat.op == lph_pkg::OP_REMOVE);
                        cmd.emit_hit   = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (stat.slot_empty || stat.probe_last)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_miss = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_REJECT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_miss = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == ST_IDLE) && !cmd.load;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lph_dp.sv
// datapath: size register, remainder unit, probe walk, slot store and result register
`timescale 1ns / 1ps
`default_nettype none

module lph_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [lph_pkg::SIZE_W-1:0]    cfg_data,
    input  wire logic [lph_pkg::OP_W-1:0]      in_command,
    input  wire logic [lph_pkg::KEY_W-1:0]     in_key,
    input  wire logic                          out_ready,
    input  wire lph_pkg::lph_cmd_t             cmd,
    output lph_pkg::lph_stat_t                 stat,
    output logic                               out_valid,
    output logic [lph_pkg::STAT_W-1:0]         out_status,
    output logic [lph_pkg::SLOT_W-1:0]         out_slot,
    output logic [lph_pkg::KEY_W-1:0]          out_key
);

    logic [lph_pkg::SIZE_W-1:0] size_reg;
    logic [lph_pkg::OP_W-1:0]   op_reg;
    logic [lph_pkg::KEY_W-1:0]  key_reg;
    logic [lph_pkg::NUM_W-1:0]  rem_reg;
    logic [lph_pkg::CNT_W-1:0]  div_cnt_reg;
    logic [lph_pkg::ADDR_W-1:0] pos_reg;
    logic [lph_pkg::NUM_W-1:0]  probe_cnt_reg;
    logic                       out_valid_reg;
    logic [lph_pkg::STAT_W-1:0] out_status_reg;
    logic [lph_pkg::SLOT_W-1:0] out_slot_reg;
    logic [lph_pkg::KEY_W-1:0]  out_key_reg;

    logic [31:0]                size_ext;
    logic [lph_pkg::NUM_W-1:0]  n_eff;
    logic [lph_pkg::CNT_W-1:0]  bit_idx;
    logic [lph_pkg::NUM_W-1:0]  rem_shift;
    logic [lph_pkg::NUM_W-1:0]  rem_next;
    logic [lph_pkg::NUM_W-1:0]  pos_inc;
    logic [lph_pkg::ADDR_W-1:0] pos_next;

    logic                       ram_we;
    logic [1:0]                 wr_state;
    logic [lph_pkg::RAM_W-1:0]  ram_rdata;
    logic [1:0]                 rd_state;
    logic [lph_pkg::KEY_W-1:0]  rd_key;

    // size zero acts as one, sizes past the store act as the store depth
    assign size_ext = 32'(size_reg);
    always_comb
    begin
        if (size_ext == 32'd0)
        begin
            n_eff = lph_pkg::NUM_W'(1);
        end
        else if (size_ext > 32'(lph_pkg::MAX_SLOTS))
        begin
            n_eff = lph_pkg::NUM_W'(lph_pkg::MAX_SLOTS);
        end
        else
        begin
            n_eff = lph_pkg::NUM_W'(size_ext);
        end
    end

    // restoring remainder, one key bit per step, msb first
    assign bit_idx   = lph_pkg::CNT_W'(lph_pkg::KEY_W - 1) - div_cnt_reg;
    assign rem_shift = {rem_reg[lph_pkg::NUM_W-2:0], key_reg[bit_idx]};
    assign rem_next  = (rem_shift >= n_eff) ? (rem_shift - n_eff) : rem_shift;

    assign pos_inc  = {1'b0, pos_reg} + lph_pkg::NUM_W'(1);
    assign pos_next = (pos_inc == n_eff) ? '0 : pos_inc[lph_pkg::ADDR_W-1:0];

    always_comb
    begin
        if (cmd.wr_used)
        begin
            wr_state = lph_pkg::SLOT_USED;
        end
        else if (cmd.wr_deleted)
        begin
            wr_state = lph_pkg::SLOT_DELETED;
        end
        else
        begin
            wr_state = lph_pkg::SLOT_EMPTY;
        end
    end

    assign ram_we = cmd.wr_used || cmd.wr_deleted || cmd.clear_step;

    lph_ram #(
        .WIDTH (lph_pkg::RAM_W),
        .DEPTH (lph_pkg::MAX_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata ({key_reg, wr_state}),
        .re    (cmd.rd),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    assign rd_state = ram_rdata[1:0];
    assign rd_key   = ram_rdata[lph_pkg::RAM_W-1:2];

    assign stat.clear_last = (pos_reg == lph_pkg::ADDR_W'(lph_pkg::MAX_SLOTS - 1));
    assign stat.div_last   = (div_cnt_reg == lph_pkg::CNT_W'(lph_pkg::KEY_W - 1));
    assign stat.op         = op_reg;
    assign stat.slot_free  = (rd_state != lph_pkg::SLOT_USED);
    assign stat.slot_empty = (rd_state == lph_pkg::SLOT_EMPTY);
    assign stat.key_match  = (rd_state == lph_pkg::SLOT_USED) && (rd_key == key_reg);
    assign stat.probe_last = (probe_cnt_reg == (n_eff - lph_pkg::NUM_W'(1)));
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= lph_pkg::SIZE_RESET;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
            if (cmd.clear_step)
            begin
                pos_reg <= pos_reg + lph_pkg::ADDR_W'(1);
            end
            else if (cmd.div_step && stat.div_last)
            begin
                pos_reg <= rem_next[lph_pkg::ADDR_W-1:0];
            end
            else if (cmd.advance)
            begin
                pos_reg <= pos_next;
            end
            if (cmd.emit_hit || cmd.emit_miss || cmd.emit_full)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_command;
            key_reg     <= in_key;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg       <= rem_next;
            div_cnt_reg   <= div_cnt_reg + lph_pkg::CNT_W'(1);
            probe_cnt_reg <= '0;
        end
        else if (cmd.advance)
        begin
            probe_cnt_reg <= probe_cnt_reg + lph_pkg::NUM_W'(1);
        end
        if (cmd.emit_hit)
        begin
            out_status_reg <= lph_pkg::RES_OK;
            out_slot_reg   <= lph_pkg::SLOT_W'(pos_reg);
            out_key_reg    <= key_reg;
        end
        else if (cmd.emit_miss || cmd.emit_full)
        begin
            out_status_reg <= cmd.emit_full ? lph_pkg::RES_FULL : lph_pkg::RES_NOT_FOUND;
            out_slot_reg   <= '0;
            out_key_reg    <= '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_key    = out_key_reg;

endmodule

`default_nettype wire

>>> rtl/core/linear_probe_hash_table_top.sv
// top level of the linear probing hash table
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | tdata                          | tuser
// s_axis    | in        | key [30:0]                     | command [1:0]
// m_axis    | out       | slot [9:0], found_key [40:10]  | status [1:0]
// cfg       | in        | cfg_data = table_size [10:0]   | -
//
// in a transaction the remainder unit spends one cycle per key bit to find the home slot,
// then each of the p probed slots gets one ram read and one check (p from 1 to size)
// an unused command runs the remainder unit but skips the probe walk and is answered from reject
// after reset a clearing pass over all 1024 slots marks every slot empty; s_tready stays low meanwhile
// a result waits in the output register; the next transaction is accepted meanwhile and
// holds in its check or reject cycle only while that register is still full

module linear_probe_hash_table_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [lph_pkg::SIZE_W-1:0]         cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [lph_pkg::IN_TDATA_W-1:0]     s_tdata,   // key
    input  wire logic [lph_pkg::OP_W-1:0]           s_tuser,   // command
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [lph_pkg::OUT_TDATA_W-1:0]    m_tdata,   // slot, found_key
    output logic      [lph_pkg::STAT_W-1:0]         m_tuser    // status
);

    lph_pkg::lph_cmd_t          cmd;
    lph_pkg::lph_stat_t         stat;
    logic [lph_pkg::SLOT_W-1:0] out_slot;
    logic [lph_pkg::KEY_W-1:0]  out_key;

    lph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lph_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_command (s_tuser),
        .in_key     (s_tdata[lph_pkg::KEY_W-1:0]),
        .out_ready  (m_tready),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_slot   (out_slot),
        .out_key    (out_key)
    );

    assign m_tdata = lph_pkg::OUT_TDATA_W'({out_key, out_slot});

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_hit, cmd.emit_miss, cmd.emit_full}))
        else $error("more than one result kind in a cycle");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_hit || cmd.emit_miss || cmd.emit_full) |-> stat.out_free)
        else $error("result written while output register is occupied");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while one is in progress");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !s_tready)
        else $error("input ready during clearing pass");

endmodule

`default_nettype wire
